FILE: rtl/assert_macros.svh
// Assertion macros used by the splitter RTL.
// Included by files that check their own logic; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define BPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge.
`define BPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`BPS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/bps_pkg.sv
// Shared types, character constants and byte classification functions
// for the pre-token splitter. Depends on nothing.
package bps_pkg;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_HYPH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] HIGH_MIN = 8'h80;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef struct packed {
		logic [7:0] data;
		logic       unit_end;
		logic       last;
	} item_t;

	// Results produced by one accepted byte; only the first num entries count.
	typedef struct packed {
		logic [1:0]      num;
		item_t [2:0]     res;
	} mark_t;

	function automatic logic is_word(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
		       (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER;
	endfunction

	function automatic logic is_joiner(input logic [7:0] b);
		return b == CH_APOS || b == CH_HYPH;
	endfunction

	// pw: previous byte is a word byte. hn, hn2: next and second next exist.
	function automatic logic ends_unit(input logic [7:0] b, input logic pw,
	                                   input logic hn, input logic [7:0] n,
	                                   input logic hn2, input logic [7:0] n2);
		logic r;
		r = 1'b1;
		if (b == CH_CR) begin
			r = !(hn && n == CH_LF);
		end else if (b == CH_LF || b == CH_SPACE || b == CH_TAB) begin
			r = 1'b1;
		end else if (is_word(b)) begin
			if (!hn)
				r = 1'b1;
			else if (is_word(n))
				r = 1'b0;
			else if (is_joiner(n) && hn2 && is_word(n2))
				r = 1'b0;
			else
				r = 1'b1;
		end else if (is_joiner(b)) begin
			r = !(pw && hn && is_word(n));
		end else if (b >= HIGH_MIN) begin
			r = !(hn && n >= HIGH_MIN);
		end
		return r;
	endfunction

endpackage

FILE: rtl/bps_marker.sv
// Marks the bytes leaving the lookahead window with their unit-end flags.
// Pure combinational logic; depends on bps_pkg.
module bps_marker (
	input  logic [7:0]     held0,
	input  logic [7:0]     held1,
	input  logic [1:0]     held_cnt,
	input  logic           prev_word,
	input  logic [7:0]     in_byte,
	input  logic           in_final,
	output bps_pkg::mark_t mark
);

	logic [7:0] w0, w1, w2;
	logic [1:0] k;

	always_comb begin
		w0 = held0;
		w1 = held1;
		w2 = in_byte;
		k  = 2'd3;
		case (held_cnt)
			2'd0: begin
				w0 = in_byte;
				w1 = 8'h00;
				w2 = 8'h00;
				k  = 2'd1;
			end
			2'd1: begin
				w1 = in_byte;
				w2 = 8'h00;
				k  = 2'd2;
			end
			default: begin
				k = 2'd3;
			end
		endcase
	end

	always_comb begin
		mark = '0;
		if (!in_final) begin
			// A full window lets the oldest byte go with two bytes of lookahead.
			if (held_cnt[1]) begin
				mark.num = 2'd1;
				mark.res[0].data = held0;
				mark.res[0].unit_end = bps_pkg::ends_unit(held0, prev_word, 1'b1, held1,
				                                          1'b1, in_byte);
				mark.res[0].last = 1'b0;
			end
		end else begin
			mark.num = k;
			mark.res[0].data = w0;
			mark.res[0].unit_end = bps_pkg::ends_unit(w0, prev_word, k > 2'd1, w1,
			                                          k > 2'd2, w2);
			mark.res[0].last = (k == 2'd1);
			mark.res[1].data = w1;
			mark.res[1].unit_end = bps_pkg::ends_unit(w1, bps_pkg::is_word(w0), k > 2'd2, w2,
			                                          1'b0, 8'h00);
			mark.res[1].last = (k == 2'd2);
			mark.res[2].data = w2;
			mark.res[2].unit_end = bps_pkg::ends_unit(w2, bps_pkg::is_word(w1), 1'b0, 8'h00,
			                                          1'b0, 8'h00);
			mark.res[2].last = (k == 2'd3);
		end
	end

endmodule

FILE: rtl/bpe_pretoken_splitter.sv
// Byte-stream pre-token splitter: passes each text byte on in order, flagged
// when it is the last byte of its unit (newline, CR or CR-LF, space or tab, a
// word run with inner apostrophes or hyphens, a run of bytes 0x80 and above,
// or any other single byte). Output trails input by two bytes because a flag
// can depend on two bytes of lookahead; the byte marked s_tlast flushes the
// window, so up to three results leave for it. Bytes are taken at one per
// cycle; the rate is set by the four-entry result queue, which accepts a new
// request only while it holds at most one result, so a final byte that
// releases three results keeps s_tready low while the queue drains. Depends on
// bps_pkg, bps_marker and assert_macros.svh.
`include "assert_macros.svh"

module bpe_pretoken_splitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,   // text_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] unit_end
	output logic       m_tlast    // last_of_text
);

	logic [7:0] held0_q, held1_q;
	logic [1:0] held_cnt_q;
	logic       prev_word_q;

	bps_pkg::mark_t mark;
	bps_pkg::item_t fifo_q [bps_pkg::FIFO_DEPTH];
	logic [bps_pkg::FIFO_AW-1:0] rd_q, wr_q;
	logic [bps_pkg::FIFO_CW-1:0] cnt_q;

	logic       accept, pop;
	logic [1:0] push_n;

	bps_marker u_marker (
		.held0     (held0_q),
		.held1     (held1_q),
		.held_cnt  (held_cnt_q),
		.prev_word (prev_word_q),
		.in_byte   (s_tdata),
		.in_final  (s_tlast),
		.mark      (mark)
	);

	assign s_tready = (cnt_q <= bps_pkg::FIFO_CW'(1));
	assign accept   = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;
	assign push_n   = accept ? mark.num : 2'd0;

	// Lookahead window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q  <= 2'd0;
			prev_word_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				held_cnt_q  <= 2'd0;
				prev_word_q <= 1'b0;
			end else if (!held_cnt_q[1]) begin
				held_cnt_q <= held_cnt_q + 2'd1;
			end else begin
				prev_word_q <= bps_pkg::is_word(held0_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !s_tlast) begin
			if (held_cnt_q == 2'd0) begin
				held0_q <= s_tdata;
			end else if (held_cnt_q == 2'd1) begin
				held1_q <= s_tdata;
			end else begin
				held0_q <= held1_q;
				held1_q <= s_tdata;
			end
		end
	end

	// Result queue: up to three entries are written at consecutive slots.
	for (genvar e = 0; e < bps_pkg::FIFO_DEPTH; e++) begin : g_ent
		logic [bps_pkg::FIFO_AW-1:0] off;
		assign off = bps_pkg::FIFO_AW'(e) - wr_q;
		always_ff @(posedge clk) begin
			if (off < push_n)
				fifo_q[e] <= mark.res[off];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			rd_q  <= rd_q + bps_pkg::FIFO_AW'(pop);
			wr_q  <= wr_q + bps_pkg::FIFO_AW'(push_n);
			cnt_q <= cnt_q + bps_pkg::FIFO_CW'(push_n) - bps_pkg::FIFO_CW'(pop);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = fifo_q[rd_q].data;
	assign m_tuser  = fifo_q[rd_q].unit_end;
	assign m_tlast  = fifo_q[rd_q].last;

	`BPS_ASSERT_NEVER(a_fifo_overflow, clk, arst_n, cnt_q > bps_pkg::FIFO_CW'(bps_pkg::FIFO_DEPTH), "result queue overflow")
	`BPS_ASSERT_NEVER(a_held_range, clk, arst_n, held_cnt_q == 2'd3, "window count out of range")
	`BPS_ASSERT(a_flush_clears, clk, arst_n, accept && s_tlast |=> held_cnt_q == 2'd0 && !prev_word_q, "window not cleared after final byte")
	`BPS_ASSERT(a_flush_emits, clk, arst_n, accept && s_tlast |=> m_tvalid, "final byte produced no result")

endmodule
